// ----- rtl/gerber_coordinate_to_fixed_top_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the coordinate converter
// Each assertion is clocked by clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef GERBER_COORDINATE_TO_FIXED_TOP_MACROS_SVH
`define GERBER_COORDINATE_TO_FIXED_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define GCF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gcf assertion failed");

// antecedent implies consequent in the next cycle
`define GCF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gcf assertion failed");

`else

`define GCF_ASSERT_IMPL(lbl, ante, cons)
`define GCF_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- rtl/gcf_pkg.sv -----
// ---------------------------------------------------------------------------
// gcf_pkg
// Shared types, codes and helpers of the coordinate converter.
// ---------------------------------------------------------------------------
`default_nettype none

package gcf_pkg;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOCFG = 2'd1,
    ST_BAD   = 2'd2,
    ST_OVF   = 2'd3
  } status_t;

  // configuration register indexes
  localparam logic [2:0] CFG_FORMAT_SET   = 3'd0;
  localparam logic [2:0] CFG_UNIT_SELECT  = 3'd1;
  localparam logic [2:0] CFG_INT_DIGITS   = 3'd2;
  localparam logic [2:0] CFG_DEC_DIGITS   = 3'd3;
  localparam logic [2:0] CFG_PAD_TRAILING = 3'd4;

  localparam logic [1:0] UNIT_MM   = 2'd1;
  localparam logic [1:0] UNIT_INCH = 2'd2;

  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_PLUS   = 8'h2B;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_PERIOD = 8'h2E;

  localparam logic [4:0] KEEP_FRAC = 5'd10;
  localparam logic [4:0] DT_MAX    = 5'd31;

  localparam logic [63:0] MAG_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MAG_NEG = 64'h8000_0000_0000_0000;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef struct packed {
    logic       format_set;
    logic [1:0] unit_select;
    logic [3:0] int_digits;
    logic [3:0] dec_digits;
    logic       pad_trailing;
  } cfg_t;

  // one classified string, ready for scaling
  typedef struct packed {
    logic [63:0]       mant;
    logic signed [6:0] k;      // decimal exponent to apply
    logic              neg;
    logic              inch;
    logic              rc;     // round up when no shift is applied
    logic              ovf;
    status_t           pstat;  // early status: ok, not configured or malformed
  } job_t;

  // quotient of v / 10 for v below 2560
  function automatic logic [7:0] div10(input logic [11:0] v);
    logic [24:0] p;
    p = {13'b0, v} * 25'd6554;
    return p[23:16];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/gerber_coordinate_to_fixed_top.sv -----
// ---------------------------------------------------------------------------
// gerber_coordinate_to_fixed_top
// Converts a coordinate string, one character per item, into a signed
// 64-bit value in units of 1e-10 mm.
// ---------------------------------------------------------------------------
//  channel   | handshake          | payload
//  ----------+--------------------+---------------------------------------
//  input     | s_tvalid/s_tready  | s_tdata = char_code, s_tlast = last_char
//  output    | m_tvalid/m_tready  | m_tdata = coord_value, m_tuser = status
//  config    | cfg_we             | cfg_index, cfg_data
//
//  Characters enter at one per cycle; the front stalls only when its
//  two-entry job queue is full.
//  The scaling unit applies one x10 step per cycle, and each /10 step is a
//  long division done one byte per cycle.
//  A result waits in the output register while the next job is scaled.
//  rst is synchronous and clears configuration, string state and queue.
// ---------------------------------------------------------------------------
`default_nettype none

module gerber_coordinate_to_fixed_top import gcf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [3:0]  cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] char_code
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // [63:0] coord_value
  output logic [1:0]       m_tuser    // [1:0] status
);

  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  job_t push_job;
  job_t pop_job;

  gcf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job)
  );

  gcf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  gcf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (q_empty),
    .pop_job  (pop_job),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

// ----- rtl/gcf_front.sv -----
// ---------------------------------------------------------------------------
// gcf_front
// Takes one character a cycle unless the job queue is full, builds the digit
// magnitude and flags, and on the last character pushes one classified job.
// ---------------------------------------------------------------------------
`default_nettype none

module gcf_front import gcf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [3:0] cfg_data,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,
  input  wire logic       s_tlast,
  input  wire logic       q_full,
  output logic            push,
  output job_t            push_job
);

  cfg_t cfg;

  logic [63:0] mantissa, mantissa_next;
  logic [4:0]  digit_total, digit_total_next;
  logic [4:0]  fraction_count, fraction_count_next;
  logic        is_negative, is_negative_next;
  logic        period_seen, period_seen_next;
  logic        round_carry, round_carry_next;
  logic        char_seen;
  logic        malformed_flag, malformed_flag_next;
  logic        overflow_flag, overflow_flag_next;

  logic        accept;
  logic        is_digit;
  logic [3:0]  digit;
  logic [67:0] prod;
  logic [4:0]  frac_kept;
  logic [4:0]  want;
  logic [4:0]  pad;
  logic signed [6:0] k_raw;
  logic        inch;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign push     = accept && s_tlast;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FORMAT_SET:   cfg.format_set   <= cfg_data[0];
        CFG_UNIT_SELECT:  cfg.unit_select  <= cfg_data[1:0];
        CFG_INT_DIGITS:   cfg.int_digits   <= cfg_data;
        CFG_DEC_DIGITS:   cfg.dec_digits   <= cfg_data;
        CFG_PAD_TRAILING: cfg.pad_trailing <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign is_digit = (s_tdata >= CHAR_ZERO) && (s_tdata <= CHAR_NINE);
  assign digit    = 4'(s_tdata - CHAR_ZERO);
  assign prod     = ({4'b0, mantissa} << 3) + ({4'b0, mantissa} << 1) + {64'b0, digit};

  always_comb begin
    mantissa_next       = mantissa;
    digit_total_next    = digit_total;
    fraction_count_next = fraction_count;
    is_negative_next    = is_negative;
    period_seen_next    = period_seen;
    round_carry_next    = round_carry;
    malformed_flag_next = malformed_flag;
    overflow_flag_next  = overflow_flag;
    if (is_digit) begin
      if (digit_total != DT_MAX) begin
        digit_total_next = digit_total + 5'd1;
      end
      if (period_seen && (fraction_count >= KEEP_FRAC)) begin
        // only the eleventh fraction digit counts, for rounding
        if (fraction_count == KEEP_FRAC) begin
          round_carry_next    = (digit >= 4'd5);
          fraction_count_next = fraction_count + 5'd1;
        end
      end else begin
        if (period_seen) begin
          fraction_count_next = fraction_count + 5'd1;
        end
        if (|prod[67:64]) begin
          overflow_flag_next = 1'b1;
          mantissa_next      = '1;
        end else begin
          mantissa_next = prod[63:0];
        end
      end
    end else if (((s_tdata == CHAR_PLUS) || (s_tdata == CHAR_MINUS)) && !char_seen) begin
      is_negative_next = (s_tdata == CHAR_MINUS);
    end else if ((s_tdata == CHAR_PERIOD) && !period_seen) begin
      period_seen_next = 1'b1;
    end else begin
      malformed_flag_next = 1'b1;
    end
  end

  // exponent of ten to apply to the magnitude
  assign inch      = (cfg.unit_select == UNIT_INCH);
  assign frac_kept = (fraction_count_next > KEEP_FRAC) ? KEEP_FRAC : fraction_count_next;
  assign want      = {1'b0, cfg.int_digits} + {1'b0, cfg.dec_digits};
  assign pad       = (cfg.pad_trailing && (digit_total_next < want)) ?
                     (want - digit_total_next) : 5'd0;

  always_comb begin
    if (period_seen_next) begin
      k_raw = $signed({2'b0, KEEP_FRAC}) - $signed({2'b0, frac_kept});
    end else begin
      k_raw = $signed({2'b0, pad}) + $signed({2'b0, KEEP_FRAC})
              - $signed({3'b0, cfg.dec_digits});
    end
  end

  always_comb begin
    push_job.mant = mantissa_next;
    push_job.k    = inch ? (k_raw - 7'sd1) : k_raw;
    push_job.neg  = is_negative_next;
    push_job.inch = inch;
    push_job.rc   = period_seen_next && round_carry_next;
    push_job.ovf  = overflow_flag_next;
    if (!cfg.format_set || ((cfg.unit_select != UNIT_MM) && !inch)) begin
      push_job.pstat = ST_NOCFG;
    end else if (malformed_flag_next || (digit_total_next == 5'd0)) begin
      push_job.pstat = ST_BAD;
    end else begin
      push_job.pstat = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      mantissa       <= '0;
      digit_total    <= '0;
      fraction_count <= '0;
      is_negative    <= 1'b0;
      period_seen    <= 1'b0;
      round_carry    <= 1'b0;
      char_seen      <= 1'b0;
      malformed_flag <= 1'b0;
      overflow_flag  <= 1'b0;
    end else if (accept) begin
      mantissa       <= mantissa_next;
      digit_total    <= digit_total_next;
      fraction_count <= fraction_count_next;
      is_negative    <= is_negative_next;
      period_seen    <= period_seen_next;
      round_carry    <= round_carry_next;
      char_seen      <= 1'b1;
      malformed_flag <= malformed_flag_next;
      overflow_flag  <= overflow_flag_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/gcf_queue.sv -----
// ---------------------------------------------------------------------------
// gcf_queue
// Short job queue between the character front and the scaling back.
// ---------------------------------------------------------------------------
`default_nettype none

module gcf_queue import gcf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output job_t      pop_job,
  output logic      empty
);

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full    = (count == (QPTR_W+1)'(QDEPTH));
  assign empty   = (count == '0);
  assign pop_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/gcf_back.sv -----
// ---------------------------------------------------------------------------
// gcf_back
// Scales one job by its power of ten, one x10 step or one byte of a /10
// division a cycle, applies the inch factor and saturates into the output.
// ---------------------------------------------------------------------------
`default_nettype none

`include "gerber_coordinate_to_fixed_top_macros.svh"

module gcf_back import gcf_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  empty,
  input  wire job_t  pop_job,
  output logic       pop,
  output logic       m_tvalid,
  input  wire logic  m_tready,
  output logic [63:0] m_tdata,
  output logic [1:0]  m_tuser
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCALE = 5'b00010,
    S_DIV   = 5'b00100,
    S_UNIT  = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t            state;
  logic [63:0]       m;
  logic signed [6:0] k;
  logic              neg;
  logic              inch;
  logic              rc;
  logic              ovf;
  status_t           pstat;
  logic [2:0]        bcnt;
  logic [3:0]        rem;

  logic [67:0] prod10;
  logic [71:0] prod254;
  logic [11:0] dv;
  logic [7:0]  dq;
  logic [11:0] dr;
  logic        k_pos;
  logic        out_free;
  logic [63:0] lim;
  logic [63:0] mag;
  logic [63:0] val;
  status_t     fstat;

  assign prod10  = ({4'b0, m} << 3) + ({4'b0, m} << 1);
  assign prod254 = ({8'b0, m} << 8) - ({8'b0, m} << 1);
  assign dv      = {rem, m[63:56]};
  assign dq      = div10(dv);
  assign dr      = dv - ({1'b0, dq, 3'b0} + {3'b0, dq, 1'b0});
  assign k_pos   = !k[6] && (k != 7'sd0);
  assign out_free = !m_tvalid || m_tready;
  assign pop     = (state == S_IDLE) && !empty;

  // saturate and apply sign
  always_comb begin
    lim = neg ? MAG_NEG : MAG_POS;
    if (pstat != ST_OK) begin
      mag   = '0;
      fstat = pstat;
    end else if (ovf || (m > lim)) begin
      mag   = lim;
      fstat = ST_OVF;
    end else begin
      mag   = m;
      fstat = ST_OK;
    end
    val = neg ? (64'd0 - mag) : mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (!empty) begin
            m     <= pop_job.ovf ? '1 : pop_job.mant;
            k     <= pop_job.k;
            neg   <= pop_job.neg;
            inch  <= pop_job.inch;
            rc    <= pop_job.rc;
            ovf   <= pop_job.ovf;
            pstat <= pop_job.pstat;
            if ((pop_job.pstat != ST_OK) || pop_job.ovf) begin
              state <= S_OUT;
            end else begin
              state <= S_SCALE;
            end
          end
        end
        S_SCALE: begin
          if (k_pos) begin
            if (|prod10[67:64]) begin
              ovf   <= 1'b1;
              m     <= '1;
              state <= S_OUT;
            end else begin
              m <= prod10[63:0];
              k <= k - 7'sd1;
            end
          end else if (k[6]) begin
            bcnt  <= '0;
            rem   <= '0;
            state <= S_DIV;
          end else begin
            if (rc) begin
              if (m == '1) begin
                ovf <= 1'b1;
              end else begin
                m <= m + 64'd1;
              end
            end
            rc    <= 1'b0;
            state <= S_UNIT;
          end
        end
        S_DIV: begin
          // long division by ten, most significant byte first
          m    <= {m[55:0], dq};
          rem  <= dr[3:0];
          bcnt <= bcnt + 3'd1;
          if (bcnt == 3'd7) begin
            rc    <= (k == -7'sd1) && (dr[3:0] >= 4'd5);
            k     <= k + 7'sd1;
            state <= S_SCALE;
          end
        end
        S_UNIT: begin
          if (inch && !ovf) begin
            if (|prod254[71:64]) begin
              ovf <= 1'b1;
            end else begin
              m <= prod254[63:0];
            end
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == S_OUT) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_OUT) && out_free) begin
      m_tdata <= val;
      m_tuser <= fstat;
    end
  end

  `GCF_ASSERT_IMPL(a_ovf_saturated, m_tvalid && (m_tuser == ST_OVF), (m_tdata == MAG_POS) || (m_tdata == MAG_NEG))
  `GCF_ASSERT_IMPL(a_error_zero, m_tvalid && ((m_tuser == ST_NOCFG) || (m_tuser == ST_BAD)), m_tdata == 64'd0)
  `GCF_ASSERT_NEXT(a_pop_leaves_idle, pop, state != S_IDLE)

endmodule

`default_nettype wire
